@@ rtl/core/sas_pkg.sv @@
// Package for the sprite animation sequencer.
// Holds command and register codes, field widths and the transaction structs.
// No dependencies.
package sas_pkg;

  localparam int TIME_W      = 24;
  localparam int FRAME_NUM_W = 10;
  localparam int FDIM_W      = 11;
  localparam int SHEET_DIM_W = 13;
  localparam int RX_W        = 12;
  localparam int RY_W        = 16;
  localparam int LEN_FIELD_W = 5;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENTRY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEADER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 2'd2;

  localparam logic [FDIM_W-1:0]      FRAME_WIDTH_RST  = 11'd10;
  localparam logic [FDIM_W-1:0]      FRAME_HEIGHT_RST = 11'd10;
  localparam logic [SHEET_DIM_W-1:0] SHEET_WIDTH_RST  = 13'd10;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [TIME_W-1:0]      elapsed;
    logic [2:0]             anim_index;
    logic [3:0]             entry_index;
    logic [FRAME_NUM_W-1:0] frame_value;
    logic [TIME_W-1:0]      delay;
    logic [LEN_FIELD_W-1:0] anim_length;
    logic                   looped;
    logic                   force_req;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_NUM_W-1:0] frame_number;
    logic [RX_W-1:0]        rect_x;
    logic [RY_W-1:0]        rect_y;
    logic                   is_finished;
    logic                   playing;
    logic                   rect_changed;
  } out_item_t;

  typedef struct packed {
    logic            done;
    logic [RX_W-1:0] x;
    logic [RY_W-1:0] y;
  } rect_res_t;

endpackage

@@ rtl/core/sas_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sas_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sas_rect.sv @@
// Frame rectangle unit: origin of a frame within the sprite sheet.
// One multiply, a bit-serial restoring divide, a second multiply, saturation.
// Depends on sas_pkg.
module sas_rect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [sas_pkg::FRAME_NUM_W-1:0]    frame_i,
  input  logic [sas_pkg::FDIM_W-1:0]         frame_w_i,
  input  logic [sas_pkg::FDIM_W-1:0]         frame_h_i,
  input  logic [sas_pkg::SHEET_DIM_W-1:0]    sheet_w_i,
  output sas_pkg::rect_res_t                 res_o
);

  localparam int P_W   = sas_pkg::FRAME_NUM_W + sas_pkg::FDIM_W;
  localparam int Y_W   = P_W + sas_pkg::FDIM_W;
  localparam int CNT_W = $clog2(P_W);
  localparam int SW    = sas_pkg::SHEET_DIM_W;

  localparam logic [2:0] R_IDLE  = 3'd0;
  localparam logic [2:0] R_MUL   = 3'd1;
  localparam logic [2:0] R_DIV   = 3'd2;
  localparam logic [2:0] R_SCALE = 3'd3;
  localparam logic [2:0] R_DONE  = 3'd4;

  logic [2:0]                      st_q, st_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [sas_pkg::FRAME_NUM_W-1:0] frame_q, frame_d;
  logic [sas_pkg::FDIM_W-1:0]      fw_q, fw_d, fh_q, fh_d;
  logic [SW-1:0]                   sw_q, sw_d;
  logic [P_W-1:0]                  p_q, p_d;
  logic [SW-1:0]                   rem_q, rem_d;
  logic [Y_W-1:0]                  y_q, y_d;

  logic [SW:0] rem_sh, rem_sub;
  logic        ge;

  // one quotient bit per cycle
  assign rem_sh  = {rem_q, p_q[P_W-1]};
  assign ge      = rem_sh >= {1'b0, sw_q};
  assign rem_sub = rem_sh - {1'b0, sw_q};

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    frame_d = frame_q;
    fw_d    = fw_q;
    fh_d    = fh_q;
    sw_d    = sw_q;
    p_d     = p_q;
    rem_d   = rem_q;
    y_d     = y_q;
    case (st_q)
      R_IDLE: begin
        if (start_i) begin
          frame_d = frame_i;
          fw_d    = frame_w_i;
          fh_d    = frame_h_i;
          // treat a zero sheet width as one
          sw_d    = (sheet_w_i == '0) ? SW'(1) : sheet_w_i;
          st_d    = R_MUL;
        end
      end
      R_MUL: begin
        p_d   = {{sas_pkg::FDIM_W{1'b0}}, frame_q} *
                {{sas_pkg::FRAME_NUM_W{1'b0}}, fw_q};
        rem_d = '0;
        cnt_d = '0;
        st_d  = R_DIV;
      end
      R_DIV: begin
        rem_d = ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
        p_d   = {p_q[P_W-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(P_W - 1)) begin
          st_d = R_SCALE;
        end
      end
      R_SCALE: begin
        y_d  = {{sas_pkg::FDIM_W{1'b0}}, p_q} * {{P_W{1'b0}}, fh_q};
        st_d = R_DONE;
      end
      R_DONE: begin
        st_d = R_IDLE;
      end
      default: begin
        st_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= R_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    fw_q    <= fw_d;
    fh_q    <= fh_d;
    sw_q    <= sw_d;
    p_q     <= p_d;
    rem_q   <= rem_d;
    y_q     <= y_d;
  end

  always_comb begin
    res_o.done = (st_q == R_DONE);
    res_o.x    = (rem_q > SW'({sas_pkg::RX_W{1'b1}})) ? {sas_pkg::RX_W{1'b1}}
                                                       : rem_q[sas_pkg::RX_W-1:0];
    res_o.y    = (|y_q[Y_W-1:sas_pkg::RY_W]) ? {sas_pkg::RY_W{1'b1}}
                                              : y_q[sas_pkg::RY_W-1:0];
  end

endmodule

@@ rtl/core/sprite_animation_sequencer.sv @@
// Sprite animation sequencer: one result per command, one command at a time.
// Accept to result valid passes S_HDR and S_OUT if the rectangle is left alone; it
// adds S_FRD and S_RECT when the frame list is read, and S_RECT for set frame or play
// of an empty list. The 21-step serial divide in sas_rect sets the time in S_RECT.
// Reset clears the control and configuration registers and the header valid bits at once; the frame list RAM holds
// no reset and an entry reads back only after a write.
module sprite_animation_sequencer #(
  parameter int NUM_ANIMS  = 8,
  parameter int MAX_FRAMES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sas_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sas_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sas_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sas_pkg::SHEET_DIM_W-1:0]     cfg_data_i
);

  localparam int AW     = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int PW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LW     = $clog2(MAX_FRAMES + 1);
  localparam int FDEPTH = NUM_ANIMS * MAX_FRAMES;
  localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int TW     = sas_pkg::TIME_W;
  localparam int HW     = TW + LW + 1;
  localparam int FNW    = sas_pkg::FRAME_NUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_FRD  = 3'd2;
  localparam logic [2:0] S_RECT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  function automatic logic [FAW-1:0] frame_addr(logic [AW-1:0] a, logic [PW-1:0] p);
    logic [31:0] s;
    s = 32'(a) * 32'(MAX_FRAMES) + 32'(p);
    return s[FAW-1:0];
  endfunction

  // configuration registers
  logic [sas_pkg::FDIM_W-1:0]      fw_q, fh_q;
  logic [sas_pkg::SHEET_DIM_W-1:0] sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= sas_pkg::FRAME_WIDTH_RST;
      fh_q <= sas_pkg::FRAME_HEIGHT_RST;
      sw_q <= sas_pkg::SHEET_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sas_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[sas_pkg::FDIM_W-1:0];
        sas_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[sas_pkg::FDIM_W-1:0];
        sas_pkg::CFG_SHEET_WIDTH:  sw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]               st_q, st_d;
  sas_pkg::in_item_t        item_q, item_d;
  logic                     active_q, active_d;
  logic [AW-1:0]            cur_q, cur_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic [TW-1:0]            acc_q, acc_d;
  logic                     done_q, done_d;
  logic [FNW-1:0]           shown_q, shown_d;
  logic [sas_pkg::RX_W-1:0] ox_q, ox_d;
  logic [sas_pkg::RY_W-1:0] oy_q, oy_d;
  logic                     changed_q, changed_d;
  logic [NUM_ANIMS-1:0]     hv_q, hv_d;
  logic                     hv_rd_q;
  logic                     out_valid_q, out_valid_d;
  sas_pkg::out_item_t       out_q, out_d;

  // memories
  logic [AW-1:0]  hdr_raddr, h_waddr;
  logic [HW-1:0]  hdr_rdata, h_wdata, hdr;
  logic           h_we;
  logic [FAW-1:0] f_raddr, f_waddr;
  logic [FNW-1:0] f_rdata;
  logic           f_we;

  sas_ram #(.WIDTH(HW), .DEPTH(NUM_ANIMS), .ADDR_W(AW)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (hdr_raddr),
    .rdata_o (hdr_rdata)
  );

  sas_ram #(.WIDTH(FNW), .DEPTH(FDEPTH), .ADDR_W(FAW)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (item_q.frame_value),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // rectangle unit
  logic               rect_start;
  logic [FNW-1:0]     rect_frame;
  sas_pkg::rect_res_t rect_res;

  sas_rect u_rect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rect_start),
    .frame_i   (rect_frame),
    .frame_w_i (fw_q),
    .frame_h_i (fh_q),
    .sheet_w_i (sw_q),
    .res_o     (rect_res)
  );

  // header read address is sampled in the accept cycle
  assign hdr_raddr = (in_data_i.command == sas_pkg::CMD_TICK) ? cur_q
                                                              : AW'(in_data_i.anim_index);

  // decoded header and command fields
  logic [TW-1:0] h_delay;
  logic [LW-1:0] h_len, len_st;
  logic          h_loop;
  logic [AW-1:0] anim_a;
  logic          anim_ok, entry_ok;
  logic          tick_en, adv, last, play_go;
  logic [TW:0]   t_sum;
  logic [TW-1:0] t_sat;
  logic [PW-1:0] new_pos;

  always_comb begin
    hdr     = hv_rd_q ? hdr_rdata : '0;
    h_delay = hdr[HW-1 -: TW];
    h_len   = hdr[LW:1];
    h_loop  = hdr[0];

    anim_a   = AW'(item_q.anim_index);
    anim_ok  = 32'(item_q.anim_index) < 32'(NUM_ANIMS);
    entry_ok = 32'(item_q.entry_index) < 32'(MAX_FRAMES);
    len_st   = (32'(item_q.anim_length) > 32'(MAX_FRAMES)) ? LW'(MAX_FRAMES)
                                                           : LW'(item_q.anim_length);

    tick_en = active_q && (h_delay != '0) && (h_len != '0) && (h_loop || !done_q);
    t_sum   = {1'b0, acc_q} + {1'b0, item_q.elapsed};
    t_sat   = t_sum[TW] ? {TW{1'b1}} : t_sum[TW-1:0];
    adv     = t_sat > h_delay;
    // a position at or past the last entry counts as the last entry
    last    = (32'(pos_q) + 32'd1) >= 32'(h_len);
    new_pos = last ? (h_loop ? '0 : pos_q) : pos_q + PW'(1);

    play_go = anim_ok && !(!item_q.force_req && active_q && (cur_q == anim_a));
  end

  assign h_waddr = anim_a;
  assign h_wdata = {item_q.delay, len_st, item_q.looped};
  assign f_waddr = frame_addr(anim_a, PW'(item_q.entry_index));

  always_comb begin
    st_d        = st_q;
    item_d      = item_q;
    active_d    = active_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    done_d      = done_q;
    shown_d     = shown_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    changed_d   = changed_q;
    hv_d        = hv_q;
    h_we        = 1'b0;
    f_we        = 1'b0;
    f_raddr     = '0;
    rect_start  = 1'b0;
    rect_frame  = shown_d;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          changed_d = 1'b0;
          st_d      = S_HDR;
        end
      end
      S_HDR: begin
        st_d = S_OUT;
        case (item_q.command)
          sas_pkg::CMD_TICK: begin
            if (tick_en) begin
              acc_d = t_sat;
              if (adv) begin
                acc_d     = t_sat - h_delay;
                pos_d     = new_pos;
                done_d    = last ? 1'b1 : done_q;
                f_raddr   = frame_addr(cur_q, new_pos);
                changed_d = 1'b1;
                st_d      = S_FRD;
              end
            end
          end
          sas_pkg::CMD_PLAY: begin
            if (play_go) begin
              cur_d     = anim_a;
              active_d  = 1'b1;
              pos_d     = '0;
              acc_d     = '0;
              // a zero delay makes a still animation, finished from the start
              done_d    = (h_delay == '0);
              changed_d = 1'b1;
              if (h_len != '0) begin
                f_raddr = frame_addr(anim_a, '0);
                st_d    = S_FRD;
              end else begin
                shown_d    = '0;
                rect_frame = shown_d;
                rect_start = 1'b1;
                st_d       = S_RECT;
              end
            end
          end
          sas_pkg::CMD_SET: begin
            active_d   = 1'b0;
            shown_d    = item_q.frame_value;
            rect_frame = shown_d;
            rect_start = 1'b1;
            changed_d  = 1'b1;
            st_d       = S_RECT;
          end
          sas_pkg::CMD_ENTRY: begin
            f_we = anim_ok && entry_ok;
          end
          sas_pkg::CMD_HEADER: begin
            if (anim_ok) begin
              h_we         = 1'b1;
              hv_d[anim_a] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_FRD: begin
        shown_d    = f_rdata;
        rect_frame = shown_d;
        rect_start = 1'b1;
        st_d       = S_RECT;
      end
      S_RECT: begin
        if (rect_res.done) begin
          ox_d = rect_res.x;
          oy_d = rect_res.y;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.frame_number = shown_q;
          out_d.rect_x       = ox_q;
          out_d.rect_y       = oy_q;
          out_d.is_finished  = done_q;
          out_d.playing      = active_q;
          out_d.rect_changed = changed_q;
          out_valid_d        = 1'b1;
          st_d               = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      active_q    <= 1'b0;
      cur_q       <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      done_q      <= 1'b0;
      shown_q     <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      changed_q   <= 1'b0;
      hv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      active_q    <= active_d;
      cur_q       <= cur_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      done_q      <= done_d;
      shown_q     <= shown_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      changed_q   <= changed_d;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    out_q   <= out_d;
    hv_rd_q <= hv_q[hdr_raddr];
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/sas_checker.sv @@
// Port-level checker for the sprite animation sequencer, bound to the top level.
// Depends on sas_pkg and sprite_animation_sequencer.
module sas_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sas_pkg::out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // one transaction at a time: ready drops right after an accept
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("in_ready_o stayed high after an input transaction");

  // ready comes back only together with the finished result
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("in_ready_o returned without a pending result");

  // no result can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared too early after an input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ dv/tb_sprite_animation_sequencer.sv @@
`timescale 1ns / 100ps
// Testbench for sprite_animation_sequencer: a directed command table, then random
// command streams, each result checked against a local model of the animation state.
// Depends on sas_pkg and the sequencer RTL.
module tb_sprite_animation_sequencer;
  import sas_pkg::*;

  localparam int NUM_ANIMS       = 8;
  localparam int MAX_FRAMES      = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_SEGMENTS    = 8;
  localparam int SEGMENT_ITEMS   = 125;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SHEET_DIM_W-1:0] cfg_data = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;
  int err_count      = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  out_item_t expected_display[$];
  stim_row_t rows[$];

  // Model state
  logic [FDIM_W-1:0]      fw_r = FRAME_WIDTH_RST;
  logic [FDIM_W-1:0]      fh_r = FRAME_HEIGHT_RST;
  logic [SHEET_DIM_W-1:0] sw_r = SHEET_WIDTH_RST;
  logic [FRAME_NUM_W-1:0] frame_mem [NUM_ANIMS][MAX_FRAMES];
  bit                     entry_seen [NUM_ANIMS][MAX_FRAMES];
  logic [TIME_W-1:0]      delay_mem [NUM_ANIMS] = '{default: '0};
  logic [LEN_FIELD_W-1:0] len_mem [NUM_ANIMS] = '{default: '0};
  logic                   loop_mem [NUM_ANIMS] = '{default: 1'b0};
  logic                   active_r = 1'b0;
  logic [2:0]             cur_r = '0;
  logic [3:0]             pos_r = '0;
  logic [TIME_W-1:0]      timer_r = '0;
  logic                   done_r = 1'b0;
  logic [FRAME_NUM_W-1:0] shown_r = '0;
  logic [RX_W-1:0]        ox_r = '0;
  logic [RY_W-1:0]        oy_r = '0;

  sprite_animation_sequencer #(
    .NUM_ANIMS (NUM_ANIMS),
    .MAX_FRAMES(MAX_FRAMES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void recompute_origin();
    longint unsigned w, p, x, y;
    w = sw_r;
    if (w == 0) w = 1;
    p = shown_r;
    p = p * fw_r;
    x = p % w;
    y = (p / w) * fh_r;
    ox_r = (x > 4095) ? '1 : x[RX_W-1:0];
    oy_r = (y > 65535) ? '1 : y[RY_W-1:0];
  endfunction

  function automatic out_item_t predict_display(input in_item_t it);
    out_item_t res;
    logic [TIME_W:0] sum;
    logic [2:0] a;
    logic chg;
    chg = 1'b0;
    a = cur_r;
    case (it.command)
      CMD_TICK: begin
        if (active_r && delay_mem[a] != '0 && len_mem[a] != '0 &&
            (loop_mem[a] || !done_r)) begin
          sum = timer_r + it.elapsed;
          if (sum > TIME_MAX) sum = TIME_MAX;
          timer_r = sum[TIME_W-1:0];
          if (timer_r > delay_mem[a]) begin
            timer_r = timer_r - delay_mem[a];
            // a position past a shortened list counts as the last entry
            if (pos_r >= len_mem[a] - 1) begin
              if (loop_mem[a]) pos_r = '0;
              done_r = 1'b1;
            end else begin
              pos_r = pos_r + 4'd1;
            end
            shown_r = frame_mem[a][pos_r];
            recompute_origin();
            chg = 1'b1;
          end
        end
      end
      CMD_PLAY: begin
        if (it.force_req || !active_r || cur_r != it.anim_index) begin
          cur_r    = it.anim_index;
          active_r = 1'b1;
          pos_r    = '0;
          timer_r  = '0;
          done_r   = (delay_mem[cur_r] == '0);
          shown_r  = (len_mem[cur_r] != '0) ? frame_mem[cur_r][0] : '0;
          recompute_origin();
          chg = 1'b1;
        end
      end
      CMD_SET: begin
        active_r = 1'b0;
        shown_r  = it.frame_value;
        recompute_origin();
        chg = 1'b1;
      end
      CMD_ENTRY: begin
        frame_mem[it.anim_index][it.entry_index]  = it.frame_value;
        entry_seen[it.anim_index][it.entry_index] = 1'b1;
      end
      CMD_HEADER: begin
        delay_mem[it.anim_index] = it.delay;
        len_mem[it.anim_index]   = (it.anim_length > MAX_FRAMES) ? 5'(MAX_FRAMES)
                                                                 : it.anim_length;
        loop_mem[it.anim_index]  = it.looped;
      end
      default: begin
      end
    endcase
    res.frame_number = shown_r;
    res.rect_x       = ox_r;
    res.rect_y       = oy_r;
    res.is_finished  = done_r;
    res.playing      = active_r;
    res.rect_changed = chg;
    return res;
  endfunction

  function automatic int written_prefix(input logic [2:0] a);
    int n;
    n = 0;
    while (n < MAX_FRAMES && entry_seen[a][n]) n++;
    return n;
  endfunction

  function automatic in_item_t mk(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] el,
                                  input logic [2:0] a, input logic [3:0] e,
                                  input logic [FRAME_NUM_W-1:0] fv, input logic [TIME_W-1:0] d,
                                  input logic [LEN_FIELD_W-1:0] len, input logic lp,
                                  input logic frc);
    in_item_t it;
    it.command     = cmd;
    it.elapsed     = el;
    it.anim_index  = a;
    it.entry_index = e;
    it.frame_value = fv;
    it.delay       = d;
    it.anim_length = len;
    it.looped      = lp;
    it.force_req   = frc;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic [FRAME_NUM_W-1:0] fn,
                                       input logic [RX_W-1:0] x,
                                       input logic [RY_W-1:0] y, input logic fin,
                                       input logic play, input logic chg);
    out_item_t o;
    o.frame_number = fn;
    o.rect_x       = x;
    o.rect_y       = y;
    o.is_finished  = fin;
    o.playing      = play;
    o.rect_changed = chg;
    return o;
  endfunction

  function automatic void add_row(input in_item_t it, input logic typed,
                                  input out_item_t want);
    stim_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.command     = CMD_W'($urandom_range(7));
    it.elapsed     = TIME_W'($urandom);
    it.anim_index  = 3'($urandom);
    it.entry_index = 4'($urandom);
    it.frame_value = FRAME_NUM_W'($urandom);
    it.delay       = TIME_W'($urandom);
    it.anim_length = LEN_FIELD_W'($urandom);
    it.looped      = 1'($urandom);
    it.force_req   = 1'($urandom);
    return it;
  endfunction

  task automatic send_cmd(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t got;
    int room, eff;
    // clip header lengths so no list entry is ever read before it is written
    if (it.command == CMD_HEADER) begin
      room = written_prefix(it.anim_index);
      eff  = (it.anim_length > MAX_FRAMES) ? MAX_FRAMES : int'(it.anim_length);
      if (eff > room) it.anim_length = LEN_FIELD_W'(room);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_display(it);
    expected_display.insert(expected_display.size(), typed ? want : got);
    if (it.command <= CMD_HEADER) items_sent++;
  endtask

  task automatic wait_idle(input int cycles);
    in_valid <= 1'b0;
    while (expected_display.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned fw, input int unsigned fh,
                                input int unsigned sw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= SHEET_DIM_W'(fw);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= SHEET_DIM_W'(fh);
    @(posedge clk);
    cfg_index <= CFG_SHEET_WIDTH;
    cfg_data  <= SHEET_DIM_W'(sw);
    @(posedge clk);
    // unused index must be ignored
    cfg_index <= CFG_SPARE;
    cfg_data  <= SHEET_DIM_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    fw_r = FDIM_W'(fw);
    fh_r = FDIM_W'(fh);
    sw_r = SHEET_DIM_W'(sw);
  endtask

  // Load a list, a header, play it and tick through it, with occasional interruptions
  task automatic run_sequence();
    in_item_t it;
    logic [2:0] a;
    int n_frames, n_ticks;
    longint unsigned d, span;
    a = 3'($urandom_range(NUM_ANIMS - 1));
    case ($urandom_range(4))
      0: n_frames = MAX_FRAMES;
      1: n_frames = 0;
      default: n_frames = $urandom_range(MAX_FRAMES, 1);
    endcase
    for (int e = 0; e < n_frames; e++) begin
      it = rand_item();
      it.command     = CMD_ENTRY;
      it.anim_index  = a;
      it.entry_index = 4'(e);
      send_cmd(it, 1'b0, '0);
    end
    it = rand_item();
    it.command    = CMD_HEADER;
    it.anim_index = a;
    if (n_frames == MAX_FRAMES && $urandom_range(1) == 1)
      it.anim_length = LEN_FIELD_W'($urandom_range(31, MAX_FRAMES + 1));
    else
      it.anim_length = LEN_FIELD_W'(n_frames);
    case ($urandom_range(7))
      0: it.delay = '0;
      1: it.delay = TIME_MAX;
      2: begin
      end
      default: it.delay = TIME_W'($urandom_range(32'h30000, 1));
    endcase
    send_cmd(it, 1'b0, '0);
    it = rand_item();
    it.command    = CMD_PLAY;
    it.anim_index = a;
    send_cmd(it, 1'b0, '0);
    n_ticks = $urandom_range(16, 2);
    for (int k = 0; k < n_ticks; k++) begin
      if ($urandom_range(11) == 0) begin
        send_cmd(rand_item(), 1'b0, '0);
      end else begin
        it = rand_item();
        it.command = CMD_TICK;
        d = delay_mem[cur_r];
        case ($urandom_range(7))
          0: it.elapsed = '0;
          1: it.elapsed = delay_mem[cur_r];
          2: it.elapsed = (d == TIME_MAX) ? TIME_MAX : TIME_W'(d + 1);
          3: begin
          end
          default: begin
            span = d + (d >> 2);
            it.elapsed = TIME_W'($urandom_range(32'(span), 0));
          end
        endcase
        send_cmd(it, 1'b0, '0);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_display.size() == 0) begin
        $error("result with no command pending: frame_number %0d", out_data.frame_number);
        err_count++;
      end else begin
        want = expected_display.pop_front();
        check_field("frame_number", want.frame_number, out_data.frame_number);
        check_field("rect_x", want.rect_x, out_data.rect_x);
        check_field("rect_y", want.rect_y, out_data.rect_y);
        check_field("is_finished", want.is_finished, out_data.is_finished);
        check_field("playing", want.playing, out_data.playing);
        check_field("rect_changed", want.rect_changed, out_data.rect_changed);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int quota;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle after reset, extreme set frame, reserved command
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_SET, 0, 0, 0, 1023, 0, 0, 0, 0), 1'b1,
            mk_out(1023, 0, 10230, 0, 0, 1));
    add_row(mk(CMD_RSVD_FIRST + 3'd2, TIME_MAX, 7, 15, 1023, TIME_MAX, 31, 1, 1),
            1'b1, mk_out(1023, 0, 10230, 0, 0, 0));
    add_row(mk(CMD_ENTRY, 0, 0, 0, 5, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_ENTRY, 0, 0, 1, 1023, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_ENTRY, 0, 0, 2, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_ENTRY, 0, 7, 15, 1023, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_HEADER, 0, 0, 0, 0, 24'h10000, 3, 1, 0), 1'b0, '0);
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // replay of the current animation without force leaves everything alone
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
    // timer equal to the delay does not advance
    add_row(mk(CMD_TICK, 24'h10000, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, TIME_MAX, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // shorten the list under the current position, then run out
    add_row(mk(CMD_HEADER, 0, 0, 0, 0, 24'h10000, 1, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, TIME_MAX, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, 24'h1234, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // empty animation with zero delay
    add_row(mk(CMD_HEADER, 0, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_PLAY, 0, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, 5, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // still animation: non-empty list, zero delay
    add_row(mk(CMD_HEADER, 0, 0, 0, 0, 0, 3, 1, 0), 1'b0, '0);
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

    foreach (rows[i]) send_cmd(rows[i].item, rows[i].typed, rows[i].want);
    wait_idle(4);

    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      case (s % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      case (s)
        0: begin
        end
        1: apply_settings(1, 1, 1);
        2: apply_settings(1024, 1024, 4096);
        3: apply_settings(7, 3, 0);
        default: apply_settings($urandom_range(2047), $urandom_range(2047),
                                $urandom_range(8191));
      endcase
      // back up the block while the sender keeps offering
      if (s == 0) hold_off_req = 1'b1;
      quota = items_sent + SEGMENT_ITEMS;
      while (items_sent < quota) begin
        if ($urandom_range(9) < 7) run_sequence();
        else send_cmd(rand_item(), 1'b0, '0);
      end
      wait_idle(4);
    end

    wait_idle(DRAIN_CYCLES);
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
